// ===== design/cle_pkg.sv =====
// ---------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the console line editor.
// ---------------------------------------------------------------------------
package cle_pkg;

  // Default line buffer depth
  localparam int BUF_DEPTH_DEF = 128;

  // Result kinds
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Request codes
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Character codes
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Pending result group handed from the controller to the emitter
  typedef struct packed {
    logic [1:0] kind;      // result kind
    logic [1:0] cnt;       // number of results, 1 to 3
    logic       bs;        // backspace, space, backspace sequence
    logic       from_ram;  // byte comes from the line store read port
    logic [7:0] data;      // byte when not from the store
  } pend_t;

endpackage

// ===== design/cle_if.sv =====
// ---------------------------------------------------------------------------
// cle_in_if / cle_out_if
// Valid/ready channels for requests and results of the line editor.
// ---------------------------------------------------------------------------
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_byte;

  modport source (output valid, output func, output char_byte, input ready);
  modport sink   (input valid, input func, input char_byte, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

// ===== design/cle_ram.sv =====
// ---------------------------------------------------------------------------
// cle_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/cle_ctrl.sv =====
// ---------------------------------------------------------------------------
// cle_ctrl
// Decode requests, keep the read/commit/edit positions and drive the line
// store ports; hand at most one pending result group per request to the emitter.
// ---------------------------------------------------------------------------
module cle_ctrl #(
  parameter int BUF_DEPTH = cle_pkg::BUF_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [7:0]                   in_char,
  output logic                         pend_valid,
  input  logic                         pend_ready,
  output cle_pkg::pend_t               pend,
  output logic                         ram_we,
  output logic [$clog2(BUF_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                   ram_wdata,
  output logic                         ram_re,
  output logic [$clog2(BUF_DEPTH)-1:0] ram_raddr
);
  import cle_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int PW = $clog2(BUF_DEPTH + 1);
  localparam logic [PW-1:0] DEPTH_P  = PW'(BUF_DEPTH);
  localparam logic [PW-1:0] DEPTH_M1 = PW'(BUF_DEPTH - 1);
  localparam logic [PW-1:0] ONE_P    = PW'(1);

  logic [PW-1:0] rd_pos_r, rd_pos_nxt;
  logic [PW-1:0] cm_pos_r, cm_pos_nxt;
  logic [PW-1:0] ed_pos_r, ed_pos_nxt;
  logic          pend_v_r;
  pend_t         pend_r, pend_nxt;
  logic          accept;
  logic          is_nl, is_bs, is_pr;
  logic [PW-1:0] rd_tmp, cm_tmp, ed_tmp;

  assign in_ready = !pend_v_r || pend_ready;
  assign accept   = in_valid && in_ready;

  assign is_nl = (in_char == CHAR_CR) || (in_char == CHAR_LF);
  assign is_bs = (in_char == CHAR_DEL) || (in_char == CHAR_BS);
  assign is_pr = (in_char >= CHAR_SPACE) && (in_char < CHAR_DEL);

  // Decode the request and work out the new positions
  always_comb begin
    rd_tmp    = rd_pos_r;
    cm_tmp    = cm_pos_r;
    ed_tmp    = ed_pos_r;
    pend_nxt  = '{kind: KIND_ECHO, cnt: 2'd0, bs: 1'b0, from_ram: 1'b0, data: CHAR_NUL};
    ram_we    = 1'b0;
    ram_wdata = in_char;
    ram_re    = 1'b0;
    if (in_func == FUNC_READ) begin
      if ((rd_pos_r < cm_pos_r) && (rd_pos_r < DEPTH_P)) begin
        ram_re            = accept;
        rd_tmp            = rd_pos_r + ONE_P;
        pend_nxt.kind     = KIND_DATA;
        pend_nxt.cnt      = 2'd1;
        pend_nxt.from_ram = 1'b1;
      end else begin
        pend_nxt.kind = KIND_EMPTY;
        pend_nxt.cnt  = 2'd1;
      end
    end else if (is_nl) begin
      if (ed_pos_r < DEPTH_P) begin
        ram_we        = accept;
        ram_wdata     = CHAR_LF;
        ed_tmp        = ed_pos_r + ONE_P;
        cm_tmp        = ed_pos_r + ONE_P;
        pend_nxt.cnt  = 2'd1;
        pend_nxt.data = CHAR_LF;
      end
    end else if (is_bs) begin
      if (ed_pos_r > cm_pos_r) begin
        ed_tmp       = ed_pos_r - ONE_P;
        pend_nxt.cnt = 2'd3;
        pend_nxt.bs  = 1'b1;
      end
    end else if (is_pr) begin
      if (ed_pos_r < DEPTH_M1) begin
        ram_we        = accept;
        ed_tmp        = ed_pos_r + ONE_P;
        pend_nxt.cnt  = 2'd1;
        pend_nxt.data = in_char;
      end
    end

    // Rewind all positions once the buffer is drained and idle
    if ((rd_tmp == cm_tmp) && (ed_tmp == cm_tmp)) begin
      rd_pos_nxt = '0;
      cm_pos_nxt = '0;
      ed_pos_nxt = '0;
    end else begin
      rd_pos_nxt = rd_tmp;
      cm_pos_nxt = cm_tmp;
      ed_pos_nxt = ed_tmp;
    end
  end

  // Store writes go to the edit end, reads come from the read position
  assign ram_waddr = ed_pos_r[AW-1:0];
  assign ram_raddr = rd_pos_r[AW-1:0];

  // Advance positions on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pos_r <= '0;
      cm_pos_r <= '0;
      ed_pos_r <= '0;
    end else if (accept) begin
      rd_pos_r <= rd_pos_nxt;
      cm_pos_r <= cm_pos_nxt;
      ed_pos_r <= ed_pos_nxt;
    end
  end

  // Hold the pending result group; drop requests that give no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (accept) begin
      pend_v_r <= (pend_nxt.cnt != 2'd0);
    end else if (pend_ready) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

  assign pend_valid = pend_v_r;
  assign pend       = pend_r;

endmodule

// ===== design/cle_emit.sv =====
// ---------------------------------------------------------------------------
// cle_emit
// Output register and result sequencer: expands one pending group into one
// to three results, taking read data from the line store.
// ---------------------------------------------------------------------------
module cle_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pend_valid,
  output logic           pend_ready,
  input  cle_pkg::pend_t pend,
  input  logic [7:0]     ram_rdata,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_byte,
  output logic           out_last
);
  import cle_pkg::*;

  logic       ob_v_r;
  logic [1:0] ob_kind_r;
  logic [7:0] ob_byte_r;
  logic [1:0] ob_rem_r;
  logic       ob_bs_r;
  logic       xfer;
  logic       done;

  assign xfer       = ob_v_r && out_ready;
  assign done       = xfer && (ob_rem_r == 2'd1);
  assign pend_ready = !ob_v_r || done;

  // Load a new group, step through a sequence, or drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_v_r <= 1'b0;
    end else if (pend_ready) begin
      ob_v_r <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_ready && pend_valid) begin
      ob_kind_r <= pend.kind;
      ob_byte_r <= pend.from_ram ? ram_rdata : pend.data;
      ob_rem_r  <= pend.cnt;
      ob_bs_r   <= pend.bs;
    end else if (xfer && !done) begin
      ob_rem_r  <= ob_rem_r - 2'd1;
    end
  end

  assign out_valid = ob_v_r;
  assign out_kind  = ob_kind_r;
  assign out_byte  = ob_bs_r ? ((ob_rem_r == 2'd2) ? CHAR_SPACE : CHAR_BS) : ob_byte_r;
  assign out_last  = (ob_rem_r == 2'd1);

endmodule

// ===== design/console_line_editor.sv =====
// ---------------------------------------------------------------------------
// console_line_editor
// Canonical console line editor: stores and echoes typed bytes, handles
// backspace and newline, and hands committed bytes to read requests.
//
//   channel  direction  fields                      transfer
//   in_ch    sink       func, char_byte             valid && ready
//   out_ch   source     kind, out_byte, last        valid && ready
//
// Each request is decoded in the cycle it is taken; positions update at once
// and the line store is written or read in that cycle. Results appear one per
// cycle while the output is not stalled, after passing through the pending slot
// and then the output register: one for echo or read, three for a backspace. A new
// request is taken while the output register still holds the previous
// group, so results can follow one another without a gap.
// Reset clears the positions and the output; the store needs no clearing.
// A stalled output holds its result and stops requests after one pending group.
// ---------------------------------------------------------------------------
module console_line_editor #(
  parameter int BUF_DEPTH = cle_pkg::BUF_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cle_in_if.sink     in_ch,
  cle_out_if.source  out_ch
);
  import cle_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);

  logic          pend_valid;
  logic          pend_ready;
  pend_t         pend;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Request decode and positions
  cle_ctrl #(.BUF_DEPTH(BUF_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_func    (in_ch.func),
    .in_char    (in_ch.char_byte),
    .pend_valid (pend_valid),
    .pend_ready (pend_ready),
    .pend       (pend),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  // Line store
  cle_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result sequencer
  cle_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .pend_valid (pend_valid),
    .pend_ready (pend_ready),
    .pend       (pend),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_kind   (out_ch.kind),
    .out_byte   (out_ch.out_byte),
    .out_last   (out_ch.last)
  );

endmodule

// ===== sim/tb_console_line_editor.sv =====
// ---------------------------------------------------------------------------
// tb_console_line_editor
// Self-checking bench for the console line editor. Drives received bytes and
// read requests with random gaps, stalls the result side at random and for
// long hold-offs, and checks every result against a directed expectation or an
// in-bench line discipline predictor: a directed table first, then random edit
// sessions and one pass that fills the line buffer to the brim.
// ---------------------------------------------------------------------------
module tb_console_line_editor;
  import cle_pkg::*;

  localparam int DEPTH        = BUF_DEPTH_DEF;
  localparam int DIR_ROWS     = 24;
  localparam int HOLD_CYCLES  = 90;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_GOAL  = 110;

  // How a directed row gets its expectation
  typedef enum logic [1:0] {NO_RESULT, ONE_RESULT, PREDICTED} plan_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       func;
    logic [7:0] ch;
    plan_t      plan;
    logic [1:0] kind;
    logic [7:0] data;
  } step_t;

  logic clk;
  logic rst_n;

  cle_in_if  in_ch ();
  cle_out_if out_ch ();

  console_line_editor #(
    .BUF_DEPTH(DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predictor state: line buffer and the three positions
  logic [7:0] line_mem [DEPTH];
  int         rd_pos;
  int         cm_pos;
  int         ed_pos;
  result_t    echo_grp [3];

  result_t    due_results [$];
  int         errors;
  int         in_count;
  int         idle_cycles;

  // Expectation source for the request currently offered
  plan_t      cur_plan;
  logic [1:0] cur_kind;
  logic [7:0] cur_data;

  // Apply one request to the predicted line state; results land in echo_grp
  function automatic int edit_and_echo(input logic func, input logic [7:0] c);
    int n;
    n = 0;
    if (func == FUNC_READ) begin
      if (rd_pos < cm_pos) begin
        echo_grp[n] = '{KIND_DATA, line_mem[rd_pos], 1'b0};
        n++;
        rd_pos++;
      end else begin
        echo_grp[n] = '{KIND_EMPTY, CHAR_NUL, 1'b0};
        n++;
      end
    end else if (c == CHAR_CR || c == CHAR_LF) begin
      if (ed_pos < DEPTH) begin
        line_mem[ed_pos] = CHAR_LF;
        ed_pos++;
        cm_pos = ed_pos;
        echo_grp[n] = '{KIND_ECHO, CHAR_LF, 1'b0};
        n++;
      end
    end else if (c == CHAR_DEL || c == CHAR_BS) begin
      if (ed_pos > cm_pos) begin
        ed_pos--;
        echo_grp[0] = '{KIND_ECHO, CHAR_BS, 1'b0};
        echo_grp[1] = '{KIND_ECHO, CHAR_SPACE, 1'b0};
        echo_grp[2] = '{KIND_ECHO, CHAR_BS, 1'b0};
        n = 3;
      end
    end else if (c >= CHAR_SPACE && c < CHAR_DEL) begin
      if (ed_pos < DEPTH - 1) begin
        line_mem[ed_pos] = c;
        ed_pos++;
        echo_grp[n] = '{KIND_ECHO, c, 1'b0};
        n++;
      end
    end
    // Reuse the buffer once everything is read and nothing is under edit
    if (rd_pos == cm_pos && ed_pos == cm_pos) begin
      rd_pos = 0;
      cm_pos = 0;
      ed_pos = 0;
    end
    if (n > 0) echo_grp[n - 1].last = 1'b1;
    return n;
  endfunction

  // Window in which neither side idles
  function automatic logic steady_phase();
    return in_count >= 150 && in_count < 230;
  endfunction

  function automatic logic [7:0] rand_print();
    return 8'($urandom_range(32, 126));
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check results and predict on every request transfer
  always @(posedge clk) begin : scoreboard
    int      n;
    result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected: kind=%0d byte=%h last=%b",
                   $time, out_ch.kind, out_ch.out_byte, out_ch.last);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_ch.kind !== want.kind) begin
            $display("%0t: kind mismatch: expected %0d, got %0d",
                     $time, want.kind, out_ch.kind);
            errors++;
          end
          if (out_ch.out_byte !== want.data) begin
            $display("%0t: byte mismatch: expected %h, got %h",
                     $time, want.data, out_ch.out_byte);
            errors++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last mismatch: expected %b, got %b",
                     $time, want.last, out_ch.last);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        n = edit_and_echo(in_ch.func, in_ch.char_byte);
        in_count++;
        case (cur_plan)
          PREDICTED: begin
            for (int i = 0; i < n; i++) due_results.push_back(echo_grp[i]);
          end
          ONE_RESULT: begin
            due_results.push_back('{cur_kind, cur_data, 1'b1});
          end
          default: ;
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls plus two long hold-offs
  initial begin : result_side
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && ((holds_done == 0 && in_count >= 40) ||
                             (holds_done == 1 && in_count >= 250))) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady_phase() || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Offer one request and hold it until the transfer
  task automatic send_req(input logic func, input logic [7:0] c, input plan_t plan,
                          input logic [1:0] kind, input logic [7:0] data);
    while (!steady_phase() && $urandom_range(0, 99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.char_byte <= c;
    cur_plan = plan;
    cur_kind = kind;
    cur_data = data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic type_key(input logic [7:0] c);
    send_req(FUNC_CHAR, c, PREDICTED, KIND_ECHO, CHAR_NUL);
  endtask

  task automatic ask_read();
    send_req(FUNC_READ, 8'($urandom_range(0, 255)), PREDICTED, KIND_ECHO, CHAR_NUL);
  endtask

  // Stimulus
  initial begin : stimulus
    step_t steps [DIR_ROWS];
    int    pick;
    int    len;
    int    n;

    errors      = 0;
    in_count    = 0;
    idle_cycles = 0;
    rd_pos      = 0;
    cm_pos      = 0;
    ed_pos      = 0;
    cur_plan    = PREDICTED;
    cur_kind    = KIND_ECHO;
    cur_data    = CHAR_NUL;
    foreach (line_mem[i]) line_mem[i] = CHAR_NUL;

    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_CHAR;
    in_ch.char_byte = CHAR_NUL;
    rst_n           = 1'b0;

    steps = '{
      '{FUNC_READ, CHAR_NUL,   ONE_RESULT, KIND_EMPTY, CHAR_NUL},   // read when empty
      '{FUNC_CHAR, CHAR_BS,    NO_RESULT,  KIND_ECHO,  CHAR_NUL},   // erase on empty line
      '{FUNC_CHAR, CHAR_DEL,   NO_RESULT,  KIND_ECHO,  CHAR_NUL},
      '{FUNC_CHAR, CHAR_NUL,   NO_RESULT,  KIND_ECHO,  CHAR_NUL},   // control bytes
      '{FUNC_CHAR, 8'hFF,      NO_RESULT,  KIND_ECHO,  CHAR_NUL},   // high bytes
      '{FUNC_CHAR, 8'h80,      NO_RESULT,  KIND_ECHO,  CHAR_NUL},
      '{FUNC_CHAR, 8'h1F,      NO_RESULT,  KIND_ECHO,  CHAR_NUL},
      '{FUNC_CHAR, CHAR_SPACE, ONE_RESULT, KIND_ECHO,  CHAR_SPACE}, // printable extremes
      '{FUNC_CHAR, 8'h7E,      ONE_RESULT, KIND_ECHO,  8'h7E},
      '{FUNC_CHAR, 8'h41,      PREDICTED,  KIND_ECHO,  CHAR_NUL},
      '{FUNC_CHAR, CHAR_DEL,   PREDICTED,  KIND_ECHO,  CHAR_NUL},   // erase with DEL
      '{FUNC_CHAR, 8'h42,      PREDICTED,  KIND_ECHO,  CHAR_NUL},
      '{FUNC_CHAR, CHAR_BS,    PREDICTED,  KIND_ECHO,  CHAR_NUL},   // erase with BS
      '{FUNC_CHAR, CHAR_CR,    ONE_RESULT, KIND_ECHO,  CHAR_LF},    // CR commits as LF
      '{FUNC_CHAR, CHAR_BS,    NO_RESULT,  KIND_ECHO,  CHAR_NUL},   // committed text stays
      '{FUNC_READ, 8'hA5,      PREDICTED,  KIND_ECHO,  CHAR_NUL},
      '{FUNC_READ, 8'h5A,      PREDICTED,  KIND_ECHO,  CHAR_NUL},
      '{FUNC_CHAR, 8'h78,      PREDICTED,  KIND_ECHO,  CHAR_NUL},   // edit while reading
      '{FUNC_READ, CHAR_NUL,   PREDICTED,  KIND_ECHO,  CHAR_NUL},
      '{FUNC_READ, CHAR_NUL,   ONE_RESULT, KIND_EMPTY, CHAR_NUL},   // only uncommitted left
      '{FUNC_CHAR, CHAR_LF,    ONE_RESULT, KIND_ECHO,  CHAR_LF},
      '{FUNC_READ, CHAR_NUL,   PREDICTED,  KIND_ECHO,  CHAR_NUL},
      '{FUNC_READ, CHAR_NUL,   PREDICTED,  KIND_ECHO,  CHAR_NUL},   // drains, buffer reused
      '{FUNC_READ, 8'hFF,      ONE_RESULT, KIND_EMPTY, CHAR_NUL}
    };

    // Reset
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    foreach (steps[i])
      send_req(steps[i].func, steps[i].ch, steps[i].plan, steps[i].kind, steps[i].data);

    // Random edit sessions
    while (in_count < RANDOM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // well-formed line, then read some of it back
        len = $urandom_range(0, 14);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 15) type_key($urandom_range(0, 1) ? CHAR_BS : CHAR_DEL);
          else type_key(rand_print());
        end
        type_key($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        n = $urandom_range(0, len + 3);
        for (int k = 0; k < n; k++) ask_read();
      end else if (pick < 70) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) ask_read();
      end else if (pick < 85) begin
        // raw noise on both fields
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
          send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   PREDICTED, KIND_ECHO, CHAR_NUL);
      end else begin
        // broken line: unterminated text, erased past its start, then a read
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) type_key(rand_print());
        for (int k = 0; k < n + 2; k++) type_key($urandom_range(0, 1) ? CHAR_BS : CHAR_DEL);
        ask_read();
      end
    end

    // Fill the buffer: printable drops at the last slot, a newline takes it, then newline drops
    for (int k = 0; k < 140; k++) begin
      if (k % 40 == 39) type_key(CHAR_BS);
      else type_key(rand_print());
    end
    type_key(CHAR_LF);
    type_key(CHAR_CR);
    type_key(8'h5A);
    type_key(CHAR_DEL);
    for (int k = 0; k < 40; k++) ask_read();

    // Drain
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
